// ===== hdl/rclfp_pkg.sv =====
// ----------------------------------------------------------------------------
// rclfp_pkg: shared constants and types of the RC link frame parser
// Frame buffer geometry, sync and kind codes, parse phases, write port type.
// ----------------------------------------------------------------------------
package rclfp_pkg;

  // frame buffer geometry
  localparam int BUFFER_BYTES  = 64;
  localparam int ADDR_W        = $clog2(BUFFER_BYTES);
  localparam int CHANNEL_COUNT = 16;
  localparam int CH_IDX_W      = $clog2(CHANNEL_COUNT);
  localparam int VALUE_W       = 11;

  // bytes holding the packed channel block, starting at frame byte 3
  localparam int FIRST_PAYLOAD = 3;
  localparam int UNPACK_BYTES  = (CHANNEL_COUNT * VALUE_W + 7) / 8;
  localparam int LEFT_W        = $clog2(UNPACK_BYTES + 1);

  // bit accumulator: up to VALUE_W-1 bits left plus one new byte
  localparam int ACC_W = VALUE_W + 7;
  localparam int CNT_W = $clog2(ACC_W + 1);

  // link codes
  localparam logic [7:0] SYNC_A        = 8'hC8;
  localparam logic [7:0] SYNC_B        = 8'hEE;
  localparam logic [7:0] SYNC_C        = 8'hEA;
  localparam logic [7:0] MAX_LENGTH    = 8'd62;
  localparam logic [7:0] MIN_LENGTH    = 8'd2;
  localparam logic [7:0] KIND_CHANNELS = 8'h16;

  // parse phases
  localparam logic [1:0] PH_SYNC    = 2'd0;
  localparam logic [1:0] PH_LEN     = 2'd1;
  localparam logic [1:0] PH_KIND    = 2'd2;
  localparam logic [1:0] PH_PAYLOAD = 2'd3;

  // buffer write port
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } buf_wr_t;

endpackage

// ===== hdl/rclfp_frame_buf.sv =====
// ----------------------------------------------------------------------------
// rclfp_frame_buf: frame byte buffer
// One write port, one registered read port. Per-entry valid bits make entries
// never written since reset read as zero.
// ----------------------------------------------------------------------------
module rclfp_frame_buf
  import rclfp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  buf_wr_t           wr,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0]              mem [BUFFER_BYTES];
  logic [BUFFER_BYTES-1:0] vld_r;
  logic [7:0]              rd_q_r;
  logic                    rd_vld_r;

  // storage write
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // valid bits, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr.en) begin
      vld_r[wr.addr] <= 1'b1;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q_r   <= mem[rd_addr];
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : 8'h00;

endmodule

// ===== hdl/rc_link_frame_parser_top.sv =====
// ----------------------------------------------------------------------------
// rc_link_frame_parser_top: RC link frame parser
// Hunts sync, stores frames in a byte buffer and unpacks packed channel frames.
// ----------------------------------------------------------------------------
// Takes one received byte per cycle when in_tready is high. A frame is sync,
// length, type, then payload and CRC until length + 2 bytes are stored;
// lengths outside 2..62 drop back to sync hunting, the CRC is not checked.
// Frames of type 0x16 are read back from the frame buffer and produce a run
// of 16 words, one per channel, tlast on channel 15. The read-back reads 22
// buffer bytes through the buffer's single registered read port, each read
// followed by a step that adds the byte to the accumulator, and emits each
// channel word in a step of its own that output stalls hold; in_tready is
// low while buffer bytes are being read and, in a following frame's payload,
// until the previous run has put its last word in the output register; a
// byte is taken every cycle otherwise. The buffer reads as zero after reset.
module rc_link_frame_parser_top
  import rclfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  // channel stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [3:0] channel_index, [14:4] channel_value, [15] zero
  output logic        out_tlast   // last_channel
);

  // parser state
  logic [1:0] phase_r, phase_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] kind_r, kind_nxt;
  logic [6:0] wpos_r, wpos_nxt;

  // unpack engine state
  logic                run_r, run_nxt;
  logic [ADDR_W-1:0]   ptr_r, ptr_nxt;
  logic [LEFT_W-1:0]   left_r, left_nxt;
  logic                pend_r, pend_nxt;
  logic [ACC_W-1:0]    acc_r, acc_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [CH_IDX_W-1:0] ch_r, ch_nxt;

  // output register
  logic                out_valid_r, out_valid_nxt;
  logic [CH_IDX_W-1:0] out_idx_r, out_idx_nxt;
  logic [VALUE_W-1:0]  out_val_r, out_val_nxt;
  logic                out_last_r, out_last_nxt;

  buf_wr_t    wr;
  logic       rd_en;
  logic [7:0] rd_data;
  logic       in_fire;
  logic       start;
  logic       rd_busy;
  logic       is_sync;
  logic [6:0] wpos_inc;
  logic       wr_ok;

  rclfp_frame_buf u_buf (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (wr),
    .rd_en   (rd_en),
    .rd_addr (ptr_r),
    .rd_data (rd_data)
  );

  // input flow control
  assign rd_busy   = run_r && ((left_r != '0) || pend_r);
  assign in_tready = !run_r || (!rd_busy && (phase_r != PH_PAYLOAD));
  assign in_fire   = in_tvalid && in_tready;

  assign is_sync  = (in_tdata == SYNC_A) || (in_tdata == SYNC_B) || (in_tdata == SYNC_C);
  assign wpos_inc = wpos_r + 7'd1;
  assign wr_ok    = (wpos_r < 7'(BUFFER_BYTES));

  // frame parser
  always_comb begin
    phase_nxt = phase_r;
    len_nxt   = len_r;
    kind_nxt  = kind_r;
    wpos_nxt  = wpos_r;
    wr.en     = 1'b0;
    wr.addr   = wpos_r[ADDR_W-1:0];
    wr.data   = in_tdata;
    start     = 1'b0;
    if (in_fire) begin
      unique case (phase_r)
        PH_SYNC: begin
          if (is_sync) begin
            wr.en     = 1'b1;
            wr.addr   = '0;
            wpos_nxt  = 7'd1;
            phase_nxt = PH_LEN;
          end
        end
        PH_LEN: begin
          len_nxt   = in_tdata;
          wr.en     = wr_ok;
          wpos_nxt  = wpos_inc;
          phase_nxt = ((in_tdata > MAX_LENGTH) || (in_tdata < MIN_LENGTH)) ? PH_SYNC : PH_KIND;
        end
        PH_KIND: begin
          kind_nxt  = in_tdata;
          wr.en     = wr_ok;
          wpos_nxt  = wpos_inc;
          phase_nxt = PH_PAYLOAD;
        end
        default: begin
          wr.en    = wr_ok;
          wpos_nxt = wpos_inc;
          if ({1'b0, wpos_inc} == (len_r + 8'd2)) begin
            phase_nxt = PH_SYNC;
            start     = (kind_r == KIND_CHANNELS);
          end
        end
      endcase
    end
  end

  // channel unpack engine: read a byte, append to accumulator, emit 11 bits
  always_comb begin
    run_nxt       = run_r;
    ptr_nxt       = ptr_r;
    left_nxt      = left_r;
    pend_nxt      = pend_r;
    acc_nxt       = acc_r;
    cnt_nxt       = cnt_r;
    ch_nxt        = ch_r;
    rd_en         = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    out_idx_nxt   = out_idx_r;
    out_val_nxt   = out_val_r;
    out_last_nxt  = out_last_r;
    if (start) begin
      run_nxt  = 1'b1;
      ptr_nxt  = ADDR_W'(FIRST_PAYLOAD);
      left_nxt = LEFT_W'(UNPACK_BYTES);
      pend_nxt = 1'b0;
      acc_nxt  = '0;
      cnt_nxt  = '0;
      ch_nxt   = '0;
    end else if (run_r) begin
      priority if (pend_r) begin
        acc_nxt  = acc_r | (ACC_W'(rd_data) << cnt_r);
        cnt_nxt  = cnt_r + CNT_W'(8);
        pend_nxt = 1'b0;
      end else if (cnt_r >= CNT_W'(VALUE_W)) begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = ch_r;
          out_val_nxt   = acc_r[VALUE_W-1:0];
          out_last_nxt  = (ch_r == CH_IDX_W'(CHANNEL_COUNT - 1));
          acc_nxt       = acc_r >> VALUE_W;
          cnt_nxt       = cnt_r - CNT_W'(VALUE_W);
          ch_nxt        = ch_r + 1'b1;
          if (ch_r == CH_IDX_W'(CHANNEL_COUNT - 1)) begin
            run_nxt = 1'b0;
          end
        end
      end else if (left_r != '0) begin
        rd_en    = 1'b1;
        ptr_nxt  = ptr_r + 1'b1;
        left_nxt = left_r - 1'b1;
        pend_nxt = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SYNC;
      len_r       <= '0;
      kind_r      <= '0;
      wpos_r      <= '0;
      run_r       <= 1'b0;
      pend_r      <= 1'b0;
      left_r      <= '0;
      cnt_r       <= '0;
      ch_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      len_r       <= len_nxt;
      kind_r      <= kind_nxt;
      wpos_r      <= wpos_nxt;
      run_r       <= run_nxt;
      pend_r      <= pend_nxt;
      left_r      <= left_nxt;
      cnt_r       <= cnt_nxt;
      ch_r        <= ch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    ptr_r      <= ptr_nxt;
    acc_r      <= acc_nxt;
    out_idx_r  <= out_idx_nxt;
    out_val_r  <= out_val_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_val_r, out_idx_r};
  assign out_tlast  = out_last_r;

endmodule

// ===== hdl/rclfp_checker.sv =====
// ----------------------------------------------------------------------------
// rclfp_checker: port-level checks of the RC link frame parser
// Watches the top-level ports only; attached by bind.
// ----------------------------------------------------------------------------
module rclfp_checker
  import rclfp_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [7:0]  in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tlast
);

  // stalled input byte holds until taken
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata))
    else $error("input byte changed while stalled");

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output word changed while stalled");

  // tlast marks the last channel
  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[3:0] == 4'(CHANNEL_COUNT - 1))
    else $error("tlast on a channel other than the last");

  // the last channel carries tlast
  a_idx_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[3:0] == 4'(CHANNEL_COUNT - 1)) |-> out_tlast)
    else $error("last channel without tlast");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind rc_link_frame_parser_top rclfp_checker u_rclfp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

// ===== dv/rc_link_frame_parser_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc_link_frame_parser_checker: channel word predictor and scoreboard
// Watches both streams of the frame parser, re-parses every accepted byte in
// its own copy of the frame buffer, and compares each channel word against the
// oldest predicted one. Reports a failure count and the number of words due.
// ----------------------------------------------------------------------------
module rc_link_frame_parser_checker
  import rclfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] rx_byte
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,   // [3:0] channel_index, [14:4] channel_value, [15] zero
  input  logic        out_tlast,   // last_channel
  output int          fail_count,
  output int          words_due
);

  // one predicted channel word
  typedef struct packed {
    logic [CH_IDX_W-1:0] idx;
    logic [VALUE_W-1:0]  value;
    logic                last;
  } chan_word_t;

  // shadow parser state
  logic [1:0]  phase_q;
  logic [7:0]  len_q;
  logic [7:0]  kind_q;
  logic [7:0]  shadow_buf [BUFFER_BYTES];
  logic [6:0]  wr_pos;
  chan_word_t  channel_run_q[$];
  int          mismatches;

  // buffer read, zero past the end
  function automatic logic [7:0] buf_at(int unsigned pos);
    return (pos < BUFFER_BYTES) ? shadow_buf[pos] : 8'h00;
  endfunction

  // buffer write, dropped past the end; position wraps at 7 bits
  task automatic store_byte(input logic [7:0] b);
    if (wr_pos < BUFFER_BYTES) shadow_buf[wr_pos] = b;
    wr_pos = wr_pos + 7'd1;
  endtask

  // unpack the 16 little-endian 11-bit values from frame byte 3 on
  task automatic predict_channel_run();
    int unsigned bitpos;
    int unsigned pos;
    logic [23:0] w;
    chan_word_t  cw;
    for (int k = 0; k < CHANNEL_COUNT; k++) begin
      bitpos   = VALUE_W * k;
      pos      = FIRST_PAYLOAD + bitpos / 8;
      w        = {buf_at(pos + 2), buf_at(pos + 1), buf_at(pos)};
      w        = w >> (bitpos % 8);
      cw.idx   = k[CH_IDX_W-1:0];
      cw.value = w[VALUE_W-1:0];
      cw.last  = (k == CHANNEL_COUNT - 1);
      channel_run_q.push_back(cw);
    end
  endtask

  // one received byte through the shadow parser
  task automatic parse_rx_byte(input logic [7:0] b);
    case (phase_q)
      PH_SYNC: begin
        if (b == SYNC_A || b == SYNC_B || b == SYNC_C) begin
          wr_pos = '0;
          store_byte(b);
          phase_q = PH_LEN;
        end
      end
      PH_LEN: begin
        len_q = b;
        store_byte(b);
        phase_q = (b > MAX_LENGTH || b < MIN_LENGTH) ? PH_SYNC : PH_KIND;
      end
      PH_KIND: begin
        kind_q = b;
        store_byte(b);
        phase_q = PH_PAYLOAD;
      end
      default: begin
        store_byte(b);
        if (int'(wr_pos) == int'(len_q) + 2) begin
          if (kind_q == KIND_CHANNELS) predict_channel_run();
          phase_q = PH_SYNC;
        end
      end
    endcase
  endtask

  // compare one accepted channel word with the oldest prediction
  task automatic check_channel_word();
    chan_word_t want;
    if (channel_run_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected channel word: ch %0d val %0d last %0b pad %0b",
                 out_tdata[3:0], out_tdata[14:4], out_tlast, out_tdata[15]);
    end else begin
      want = channel_run_q.pop_front();
      if (out_tdata[3:0] !== want.idx || out_tdata[14:4] !== want.value ||
          out_tlast !== want.last || out_tdata[15] !== 1'b0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("channel word mismatch: exp ch %0d val %0d last %0b pad 0, got ch %0d val %0d last %0b pad %0b",
                   want.idx, want.value, want.last,
                   out_tdata[3:0], out_tdata[14:4], out_tlast, out_tdata[15]);
      end
    end
  endtask

  // output side first so a same-cycle word cannot match a fresh prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      phase_q = PH_SYNC;
      len_q   = '0;
      kind_q  = '0;
      wr_pos  = '0;
      foreach (shadow_buf[i]) shadow_buf[i] = 8'h00;
      channel_run_q.delete();
      mismatches = 0;
    end else begin
      if (out_tvalid && out_tready) check_channel_word();
      if (in_tvalid && in_tready) parse_rx_byte(in_tdata);
    end
    fail_count <= mismatches;
    words_due  <= channel_run_q.size();
  end

endmodule

// ===== dv/rc_link_frame_parser_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc_link_frame_parser_top_tb: testbench of the RC link frame parser
// Feeds directed and random byte streams (good, bad-length, foreign-type and
// short frames plus line noise) with random gaps and output stalls, including
// one long output hold-off, and leaves checking to the checker module.
// ----------------------------------------------------------------------------
module rc_link_frame_parser_top_tb;
  import rclfp_pkg::*;

  localparam int IDLE_LIMIT   = 1000;  // cycles without any byte or word moving
  localparam int LONG_HOLD    = 150;   // receiver hold-off, fills the block
  localparam int HOLD_AT_WORD = 40;
  localparam int RAND_BYTES   = 75;
  localparam int DRAIN_CYCLES = 150;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tlast;
  int          fail_count;
  int          words_due;
  int          idle_cycles = 0;
  int          bytes_sent  = 0;
  int          frame_bytes_sent = 0;
  int          channel_frames   = 0;

  always #10 clk = ~clk;

  rc_link_frame_parser_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  rc_link_frame_parser_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .fail_count (fail_count),
    .words_due  (words_due)
  );

  // watchdog: ends the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // offer one byte after a random gap, return once it is taken
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = (((bytes_sent / 20) % 3) == 2) ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
  endtask

  function automatic logic [7:0] pick_sync();
    case ($urandom_range(0, 2))
      0:       return SYNC_A;
      1:       return SYNC_B;
      default: return SYNC_C;
    endcase
  endfunction

  // sync, length, kind, then length - 1 random payload and CRC bytes
  task automatic send_frame(input logic [7:0] kind, input int len);
    send_byte(pick_sync());
    send_byte(len[7:0]);
    send_byte(kind);
    repeat (len - 1) send_byte(8'($urandom_range(0, 255)));
    frame_bytes_sent += len + 2;
    if (kind == KIND_CHANNELS) channel_frames++;
  endtask

  // receiver: random stalls, one long hold-off while the sender keeps going
  initial begin : receiver
    int gap;
    int words;
    words = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (words == HOLD_AT_WORD) gap = LONG_HOLD;
      else if (((words / 24) % 3) == 1) gap = 0;
      else gap = $urandom_range(0, 5);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      words++;
    end
  end

  // stimulus and verdict
  initial begin : stimulus
    logic [7:0] directed [$];
    int         r;
    int         len;
    logic [7:0] kind;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // noise while hunting sync
    directed = {8'h00, 8'hFF};
    // too long, too short, zero and largest length bytes
    directed = {directed, SYNC_A, 8'd63, SYNC_B, 8'd1, SYNC_C, 8'd0, SYNC_A, 8'hFF};
    // shortest channel frame: unpacking reads the payload byte and zeros
    directed = {directed, SYNC_B, MIN_LENGTH, KIND_CHANNELS, 8'h5A};
    // foreign kind completes silently
    directed = {directed, SYNC_A, 8'd3, 8'h28, 8'h11, 8'h22};
    // short channel frame mixing fresh and never-written zero buffer bytes
    directed = {directed, SYNC_C, 8'd5, KIND_CHANNELS, 8'hFF, 8'hFF, 8'hFF, 8'h3C};
    foreach (directed[i]) send_byte(directed[i]);

    // random part: mostly well-formed frames with random content
    while (frame_bytes_sent < RAND_BYTES || channel_frames < 2) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(MIN_LENGTH, MAX_LENGTH) : 24;
        send_frame(KIND_CHANNELS, len);
      end else if (r < 75) begin
        do kind = 8'($urandom_range(0, 255)); while (kind == KIND_CHANNELS);
        len = ($urandom_range(0, 4) == 0) ? int'(MAX_LENGTH) : $urandom_range(MIN_LENGTH, 10);
        send_frame(kind, len);
      end else if (r < 85) begin
        send_byte(pick_sync());
        if ($urandom_range(0, 1) == 0) send_byte(8'($urandom_range(0, MIN_LENGTH - 1)));
        else send_byte(8'($urandom_range(MAX_LENGTH + 1, 255)));
        frame_bytes_sent += 2;
      end else begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
      end
    end
    in_tvalid <= 1'b0;

    // drain outstanding channel words, then watch for strays
    @(posedge clk);
    while (words_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && words_due == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
